### hdl/sm3_pkg.sv
// ----------------------------------------------------------------------------
// SM3 hash engine package
// Shared constants and round helper functions.
// ----------------------------------------------------------------------------
package sm3_pkg;
    localparam logic [31:0] T_LOW  = 32'h79CC4519;
    localparam logic [31:0] T_HIGH = 32'h7A879D8A;
    localparam logic [255:0] SM3_IV = {
        32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
        32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E};

    typedef logic [31:0] t_word;

    function automatic t_word rotl(input t_word x, input logic [4:0] n);
        logic [63:0] d;
        d = {x, x} << n;
        return d[63:32];
    endfunction

    function automatic t_word perm0(input t_word x);
        return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
    endfunction

    function automatic t_word perm1(input t_word x);
        return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
    endfunction
endpackage

### hdl/sm3_hash_engine.sv
// ----------------------------------------------------------------------------
// SM3 hash engine
// Packs message bytes into blocks, pads, compresses, streams the digest.
// ----------------------------------------------------------------------------
// An accepted input beat is packed one valid byte at a time, after which the
// input side is ready again. A beat that completes a 64-byte block also runs
// the load, the rounds and the fold in the shared round unit before packing
// goes on. An end-of-message beat runs one or two padding compressions and
// then sends eight digest beats, word 0 first; no input is taken meanwhile.
module sm3_hash_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // data_word[31:0], byte_count[34:32]
    input  logic        s_axis_tlast,   // end_of_message
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // digest_word[31:0], word_index[34:32]
    output logic        m_axis_tlast    // last_word
);
    import sm3_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PACK = 3'd1;
    localparam logic [2:0] ST_LOAD = 3'd2;
    localparam logic [2:0] ST_RUN  = 3'd3;
    localparam logic [2:0] ST_FOLD = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0]   r_st;
    logic [60:0]  r_len;
    logic [511:0] r_blk;
    logic [255:0] r_cv;
    logic [31:0]  r_data;
    logic [2:0]   r_cnt;
    logic         r_end;
    logic [1:0]   r_pad;     // 0 none, 2 a second padding block follows
    logic         r_final;   // current compression is the final one
    logic [5:0]   r_round;
    logic [2:0]   r_oidx;
    logic [511:0] blk_in;
    logic [511:0] pad_blk;
    logic [255:0] st;
    logic [5:0]   pos;
    logic [63:0]  bits;

    assign s_axis_tready = (r_st == ST_IDLE);
    assign pos  = r_len[5:0];
    assign bits = {r_len, 3'b000};

    sm3_round u_round (
        .i_clk   (i_clk),
        .i_load  (r_st == ST_LOAD),
        .i_step  (r_st == ST_RUN),
        .i_round (r_round),
        .i_v     (r_cv),
        .i_block (r_blk),
        .o_state (st)
    );

    always_comb begin
        blk_in = r_blk;
        blk_in[511 - 8*pos -: 8] = r_data[31:24];
    end

    // pad: keep bytes below pos, then 0x80, then zeros; length if it fits
    always_comb begin
        pad_blk = r_blk;
        for (int b = 0; b < 64; b++) begin
            if (b == pos)
                pad_blk[511-8*b -: 8] = 8'h80;
            else if (b > pos)
                pad_blk[511-8*b -: 8] = 8'h00;
        end
        if (pos < 6'd56) pad_blk[63:0] = bits;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE; r_len <= '0; r_cv <= SM3_IV; r_round <= '0;
            r_oidx <= '0; r_pad <= '0; r_final <= 1'b0;
        end else begin
            case (r_st)
                ST_IDLE: if (s_axis_tvalid) begin
                    r_data <= s_axis_tdata[31:0];
                    r_cnt  <= (s_axis_tdata[34:32] > 3'd4) ? 3'd4 : s_axis_tdata[34:32];
                    r_end  <= s_axis_tlast;
                    r_st   <= ST_PACK;
                end
                ST_PACK: begin
                    if (r_cnt != 3'd0) begin
                        r_blk  <= blk_in;
                        r_data <= {r_data[23:0], 8'h00};
                        r_cnt  <= r_cnt - 3'd1;
                        r_len  <= r_len + 61'd1;
                        if (pos == 6'd63) begin
                            r_final <= 1'b0;
                            r_st <= ST_LOAD;
                        end
                    end else if (r_end) begin
                        r_blk <= pad_blk;
                        if (pos >= 6'd56) begin
                            r_pad   <= 2'd2;
                            r_final <= 1'b0;
                        end else begin
                            r_final <= 1'b1;
                        end
                        r_st <= ST_LOAD;
                    end else begin
                        r_st <= ST_IDLE;
                    end
                end
                ST_LOAD: begin
                    r_round <= '0;
                    r_st <= ST_RUN;
                end
                ST_RUN: begin
                    r_round <= r_round + 6'd1;
                    if (r_round == 6'd63) r_st <= ST_FOLD;
                end
                ST_FOLD: begin
                    r_cv <= r_cv ^ st;
                    if (r_final) begin
                        r_oidx <= '0;
                        r_final <= 1'b0;
                        r_st <= ST_OUT;
                    end else if (r_pad == 2'd2) begin
                        r_blk   <= {448'd0, bits};
                        r_pad   <= '0;
                        r_final <= 1'b1;
                        r_st    <= ST_LOAD;
                    end else begin
                        r_st <= ST_PACK;
                    end
                end
                ST_OUT: if (m_axis_tready) begin
                    r_oidx <= r_oidx + 3'd1;
                    if (r_oidx == 3'd7) begin
                        r_cv <= SM3_IV; r_len <= '0; r_st <= ST_IDLE;
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = (r_st == ST_OUT);
    assign m_axis_tdata  = {5'd0, r_oidx, r_cv[255 - 32*r_oidx -: 32]};
    assign m_axis_tlast  = (r_oidx == 3'd7);

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !m_axis_tvalid) else $error("ready while sending digest");
    a_round_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_LOAD) |=> (r_st == ST_RUN && r_round == 6'd0))
        else $error("round count not cleared");
    a_out_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> (r_len == 61'd0))
        else $error("length not cleared after digest");
endmodule

### hdl/sm3_round.sv
// ----------------------------------------------------------------------------
// SM3 round unit
// One compression round plus a rolling 16-word message schedule window.
// ----------------------------------------------------------------------------
module sm3_round (
    input  logic                 i_clk,
    input  logic                 i_load,    // load V and block
    input  logic                 i_step,    // run one round
    input  logic [5:0]           i_round,
    input  logic [255:0]         i_v,
    input  logic [511:0]         i_block,   // word 0 in the top bits
    output logic [255:0]         o_state
);
    import sm3_pkg::*;

    t_word r_w [16];
    t_word r_s [8];
    t_word w_new, a12, ss1, ss2, ff, gg, tt1, tt2, tj;

    always_comb begin
        w_new = perm1(r_w[0] ^ r_w[7] ^ rotl(r_w[13], 5'd15))
              ^ rotl(r_w[3], 5'd7) ^ r_w[10];
        tj  = rotl((i_round < 6'd16) ? T_LOW : T_HIGH, i_round[4:0]);
        a12 = rotl(r_s[0], 5'd12);
        ss1 = rotl(a12 + r_s[4] + tj, 5'd7);
        ss2 = ss1 ^ a12;
        if (i_round < 6'd16) begin
            ff = r_s[0] ^ r_s[1] ^ r_s[2];
            gg = r_s[4] ^ r_s[5] ^ r_s[6];
        end else begin
            ff = (r_s[0] & r_s[1]) | (r_s[0] & r_s[2]) | (r_s[1] & r_s[2]);
            gg = (r_s[4] & r_s[5]) | (~r_s[4] & r_s[6]);
        end
        tt1 = ff + r_s[3] + ss2 + (r_w[0] ^ r_w[4]);
        tt2 = gg + r_s[7] + ss1 + r_w[0];
        for (int k = 0; k < 8; k++) begin
            o_state[255-32*k -: 32] = r_s[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int k = 0; k < 16; k++) r_w[k] <= i_block[511-32*k -: 32];
            for (int k = 0; k < 8; k++)  r_s[k] <= i_v[255-32*k -: 32];
        end else if (i_step) begin
            for (int k = 0; k < 15; k++) r_w[k] <= r_w[k+1];
            r_w[15] <= w_new;
            r_s[3] <= r_s[2];
            r_s[2] <= rotl(r_s[1], 5'd9);
            r_s[1] <= r_s[0];
            r_s[0] <= tt1;
            r_s[7] <= r_s[6];
            r_s[6] <= rotl(r_s[5], 5'd19);
            r_s[5] <= r_s[4];
            r_s[4] <= perm0(tt2);
        end
    end
endmodule

### dv/sm3_hash_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SM3 hash engine checker
// Watches both stream channels. Packs accepted message bytes into its own
// copy of the block, computes the SM3 digest on each end-of-message beat and
// compares every digest beat field by field with the oldest expected word.
// ----------------------------------------------------------------------------
module sm3_hash_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [39:0] i_s_tdata,      // data_word[31:0], byte_count[34:32]
    input  logic        i_s_tlast,      // end_of_message
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [39:0] i_m_tdata,      // digest_word[31:0], word_index[34:32]
    input  logic        i_m_tlast,      // last_word
    output int          o_fail_count,
    output int          o_pending,
    output int          o_digests_seen
);
    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } t_digest_beat;

    localparam logic [31:0] IV_WORDS [8] = '{
        32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
        32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E};

    logic [31:0]  chain [8];
    logic [31:0]  msg_block [16];
    logic [60:0]  msg_bytes;
    t_digest_beat digest_q [$];
    int           fails;
    int           beats_seen;

    assign o_fail_count   = fails;
    assign o_pending      = digest_q.size();
    assign o_digests_seen = beats_seen;

    function automatic logic [31:0] rol(input logic [31:0] x, input int n);
        int k;
        k = n % 32;
        return (k == 0) ? x : ((x << k) | (x >> (32 - k)));
    endfunction

    task automatic compress_block(input logic [31:0] blk [16]);
        logic [31:0] w [68];
        logic [31:0] a, b, c, d, e, f, g, h;
        logic [31:0] a12, ss1, ss2, ff, gg, tt1, tt2, tj, x;
        for (int j = 0; j < 16; j++) w[j] = blk[j];
        for (int j = 16; j < 68; j++) begin
            x = w[j-16] ^ w[j-9] ^ rol(w[j-3], 15);
            w[j] = x ^ rol(x, 15) ^ rol(x, 23) ^ rol(w[j-13], 7) ^ w[j-6];
        end
        {a, b, c, d, e, f, g, h} = {chain[0], chain[1], chain[2], chain[3],
                                    chain[4], chain[5], chain[6], chain[7]};
        for (int j = 0; j < 64; j++) begin
            tj  = (j < 16) ? 32'h79CC4519 : 32'h7A879D8A;
            a12 = rol(a, 12);
            ss1 = rol(a12 + e + rol(tj, j), 7);
            ss2 = ss1 ^ a12;
            if (j < 16) begin
                ff = a ^ b ^ c;
                gg = e ^ f ^ g;
            end else begin
                ff = (a & b) | (a & c) | (b & c);
                gg = (e & f) | (~e & g);
            end
            tt1 = ff + d + ss2 + (w[j] ^ w[j+4]);
            tt2 = gg + h + ss1 + w[j];
            d = c; c = rol(b, 9); b = a; a = tt1;
            h = g; g = rol(f, 19); f = e;
            e = tt2 ^ rol(tt2, 9) ^ rol(tt2, 17);
        end
        chain[0] ^= a; chain[1] ^= b; chain[2] ^= c; chain[3] ^= d;
        chain[4] ^= e; chain[5] ^= f; chain[6] ^= g; chain[7] ^= h;
    endtask

    task automatic absorb_byte(input logic [7:0] bval);
        int pos;
        pos = msg_bytes[5:0];
        msg_block[pos/4][(3 - pos%4)*8 +: 8] = bval;
        msg_bytes = msg_bytes + 1'b1;
        if (msg_bytes[5:0] == 0) compress_block(msg_block);
    endtask

    // Pad, fold in the bit length and queue the eight digest words.
    task automatic close_message();
        logic [31:0] pad [16];
        logic [63:0] bit_len;
        int left;
        left    = msg_bytes[5:0];
        bit_len = {msg_bytes, 3'b000};
        for (int i = 0; i < 16; i++) pad[i] = (i <= left/4) ? msg_block[i] : 32'h0;
        for (int k = left % 4; k < 4; k++) pad[left/4][(3 - k)*8 +: 8] = 8'h00;
        pad[left/4][(3 - left%4)*8 +: 8] = 8'h80;
        if (left >= 56) begin
            compress_block(pad);
            for (int i = 0; i < 16; i++) pad[i] = 32'h0;
        end
        pad[14] = bit_len[63:32];
        pad[15] = bit_len[31:0];
        compress_block(pad);
        for (int i = 0; i < 8; i++)
            digest_q.push_back('{word: chain[i], index: 3'(i), last: (i == 7)});
        chain     = IV_WORDS;
        msg_bytes = '0;
    endtask

    always @(posedge i_clk) begin
        t_digest_beat exp_beat;
        int cnt;
        if (!i_rst_n) begin
            chain     = IV_WORDS;
            msg_bytes = '0;
            for (int i = 0; i < 16; i++) msg_block[i] = 32'h0;
            digest_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                beats_seen++;
                if (digest_q.size() == 0) begin
                    $error("digest beat with no expected word: data %h", i_m_tdata);
                    fails++;
                end else begin
                    exp_beat = digest_q.pop_front();
                    if (i_m_tdata[31:0] !== exp_beat.word) begin
                        $error("digest_word: expected %h, got %h",
                               exp_beat.word, i_m_tdata[31:0]);
                        fails++;
                    end
                    if (i_m_tdata[34:32] !== exp_beat.index) begin
                        $error("word_index: expected %0d, got %0d",
                               exp_beat.index, i_m_tdata[34:32]);
                        fails++;
                    end
                    if (i_m_tlast !== exp_beat.last) begin
                        $error("last_word: expected %0b, got %0b",
                               exp_beat.last, i_m_tlast);
                        fails++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                cnt = i_s_tdata[34:32];
                if (cnt > 4) cnt = 4;
                for (int i = 0; i < cnt; i++)
                    absorb_byte(i_s_tdata[31 - 8*i -: 8]);
                if (i_s_tlast) close_message();
            end
        end
    end

    initial begin
        fails      = 0;
        beats_seen = 0;
        chain      = IV_WORDS;
        msg_bytes  = '0;
    end
endmodule

### dv/tb_sm3_hash_engine.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SM3 hash engine testbench
// Streams directed and random messages with varied byte counts and lengths
// through the engine under changing idle and stall patterns; the checker
// predicts and compares every digest beat.
// ----------------------------------------------------------------------------
module tb_sm3_hash_engine;
    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;      // data_word[31:0], byte_count[34:32]
    logic        s_axis_tlast;      // end_of_message
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;      // digest_word[31:0], word_index[34:32]
    logic        m_axis_tlast;      // last_word

    int fail_count, pending, digest_beats;
    int send_idle_pct, recv_stall_pct;
    int words_sent, messages_sent;

    sm3_hash_engine dut (
        .i_clk, .i_rst_n,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
    );

    sm3_hash_checker checker_i (
        .i_clk, .i_rst_n,
        .i_s_tvalid(s_axis_tvalid), .i_s_tready(s_axis_tready),
        .i_s_tdata(s_axis_tdata), .i_s_tlast(s_axis_tlast),
        .i_m_tvalid(m_axis_tvalid), .i_m_tready(m_axis_tready),
        .i_m_tdata(m_axis_tdata), .i_m_tlast(m_axis_tlast),
        .o_fail_count(fail_count), .o_pending(pending),
        .o_digests_seen(digest_beats)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Hold the beat until the engine takes it; idle gaps come first.
    task automatic send_word(input logic [31:0] data, input logic [2:0] cnt,
                             input logic eom);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, cnt, data};
        s_axis_tlast  <= eom;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        words_sent++;
        if (eom) messages_sent++;
    endtask

    task automatic send_message(input int nwords, input bit ragged);
        logic [31:0] data;
        logic [2:0]  cnt;
        for (int i = 0; i < nwords; i++) begin
            case ($urandom_range(9))
                0:       data = 32'h0;
                1:       data = 32'hFFFFFFFF;
                default: data = $urandom;
            endcase
            cnt = (ragged && $urandom_range(3) == 0) ? 3'($urandom_range(7)) : 3'd4;
            send_word(data, cnt, i == nwords - 1);
        end
    endtask

    task automatic set_phase();
        case ((words_sent * 4) / 330)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
            default: begin send_idle_pct = 13; recv_stall_pct = 13; end
        endcase
    endtask

    initial begin
        int len;
        bit paused;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tlast   = 1'b0;
        m_axis_tready  = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        words_sent     = 0;
        messages_sent  = 0;
        paused         = 0;
        i_rst_n        = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty message, "abc", odd and zero counts mid-message,
        // all-zero and all-one words, a length at the padding boundary.
        send_word(32'h0, 3'd0, 1'b1);
        send_word(32'h61626300, 3'd3, 1'b1);
        send_word(32'hFFFFFFFF, 3'd7, 1'b0);
        send_word(32'h12345678, 3'd0, 1'b0);
        send_word(32'hA5A5A5A5, 3'd5, 1'b0);
        send_word(32'h00000000, 3'd6, 1'b0);
        send_word(32'hDEADBEEF, 3'd1, 1'b0);
        send_word(32'hCAFEF00D, 3'd2, 1'b0);
        send_word(32'h0, 3'd0, 1'b1);
        for (int i = 0; i < 14; i++)
            send_word(32'hFFFFFFFF, 3'd4, i == 13);

        while (words_sent < 330) begin
            set_phase();
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5, 6: len = $urandom_range(1, 6);
                7, 8:                len = $urandom_range(7, 20);
                default:             len = $urandom_range(17, 40);
            endcase
            send_message(len, 1'($urandom_range(1)));
            // Drain once mid-run before going on.
            if (!paused && words_sent > 160) begin
                paused = 1;
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);

        $display("Sent %0d words in %0d messages, checked %0d digest beats.",
                 words_sent, messages_sent, digest_beats);
        $display("Covered byte counts 0 to 7, empty and multi-block messages.");
        if (fail_count == 0) begin
            $display("sm3_hash_engine verification clean");
        end else begin
            $display("sm3_hash_engine verification failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("sm3_hash_engine verification failed");
        $finish;
    end
endmodule

### sim.f
hdl/sm3_pkg.sv
hdl/sm3_round.sv
hdl/sm3_hash_engine.sv
dv/sm3_hash_checker.sv
dv/tb_sm3_hash_engine.sv
